/* rtl/core/imh_pkg.sv */
// Package for the indexed min-heap: field widths, operation and status codes,
// request/response structs and the controller-to-datapath command set.
// Depends on nothing; imh_ctrl, imh_dp and the top level import it.
package imh_pkg;

  // Fixed widths of the interface fields.
  localparam int ITEM_W   = 10;
  localparam int IKEY_W   = 16;
  localparam int LCNT_W   = 11;
  localparam int ID_DEPTH = 1 << ITEM_W;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_KEY_BITS = 16;

  // Operation codes.
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_BUILD   = 3'd2;
  localparam logic [2:0] OP_EXTRACT = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;
  localparam logic [2:0] OP_DEC     = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOTP  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [ITEM_W-1:0] item_id;
    logic [IKEY_W-1:0] item_key;
  } imh_req_t;

  typedef struct packed {
    logic [ITEM_W-1:0] out_item;
    logic [IKEY_W-1:0] out_key;
    logic [1:0]        status;
    logic [LCNT_W-1:0] live_count;
  } imh_rsp_t;

  // One command per controller step; the datapath decodes it.
  typedef enum logic [4:0] {
    CMD_IDLE, CMD_DISP, CMD_EXT_A, CMD_EXT_B, CMD_TAKE_A, CMD_TAKE_B, CMD_TAKE_C,
    CMD_UP_A, CMD_UP_B, CMD_UP_C, CMD_DN_A, CMD_DN_B, CMD_DN_D, CMD_DN_E,
    CMD_CMP, CMD_DN_F, CMD_FIN, CMD_BLD_N, CMD_BLD_A, CMD_BLD_B, CMD_CLR, CMD_DONE
  } imh_cmd_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       valid_id;
    logic       here;
    logic       full;
    logic       empty;
    logic       hole_zero;
    logic       first;
    logic       up_gt;
    logic       r_in;
    logic       l_in;
    logic       bc;
    logic       bi_zero;
    logic       take_need;
    logic       swp_last;
  } imh_sts_t;

endpackage

/* rtl/core/imh_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/imh_ctrl.sv */
// Controller state machine of the indexed min-heap: sequences each operation and its sift steps.
// Depends on imh_pkg; drives the command into imh_dp and reads its status.
module imh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  imh_pkg::imh_sts_t sts_i,
  output imh_pkg::imh_cmd_e cmd_o,
  output logic              busy,
  output logic              done_o
);
  import imh_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_DISP   = 23'h000002,
    S_EXT_A  = 23'h000004,
    S_EXT_B  = 23'h000008,
    S_TAKE_A = 23'h000010,
    S_TAKE_B = 23'h000020,
    S_TAKE_C = 23'h000040,
    S_UP_A   = 23'h000080,
    S_UP_B   = 23'h000100,
    S_UP_C   = 23'h000200,
    S_DN_A   = 23'h000400,
    S_DN_B   = 23'h000800,
    S_DN_C   = 23'h001000,
    S_DN_D   = 23'h002000,
    S_DN_E   = 23'h004000,
    S_DN_G   = 23'h008000,
    S_DN_F   = 23'h010000,
    S_FIN    = 23'h020000,
    S_BLD_N  = 23'h040000,
    S_BLD_A  = 23'h080000,
    S_BLD_B  = 23'h100000,
    S_CLR    = 23'h200000,
    S_DONE   = 23'h400000
  } state_e;

  state_e state_q, state_d;
  logic   init_q, init_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DISP;
      end
      S_DISP: begin
        case (sts_i.op)
          OP_CLEAR:   state_d = S_CLR;
          OP_LOAD:    state_d = (sts_i.valid_id && sts_i.here) ? S_UP_A : S_DONE;
          OP_BUILD:   state_d = S_BLD_N;
          OP_EXTRACT: state_d = sts_i.empty ? S_DONE : S_EXT_A;
          OP_REMOVE:  state_d = sts_i.here ? S_TAKE_A : S_DONE;
          OP_DEC:     state_d = sts_i.here ? S_UP_A : S_DONE;
          default:    state_d = S_DONE;
        endcase
      end
      S_EXT_A:  state_d = S_EXT_B;
      S_EXT_B:  state_d = S_TAKE_A;
      S_TAKE_A: state_d = sts_i.take_need ? S_TAKE_B : S_DONE;
      S_TAKE_B: state_d = S_TAKE_C;
      S_TAKE_C: state_d = S_UP_A;
      S_UP_A: begin
        if (!sts_i.hole_zero) state_d = S_UP_B;
        else                  state_d = sts_i.first ? S_DN_A : S_FIN;
      end
      S_UP_B: state_d = S_UP_C;
      S_UP_C: begin
        if (sts_i.up_gt)     state_d = S_UP_A;
        else if (sts_i.first) state_d = S_DN_A;
        else                  state_d = S_FIN;
      end
      S_DN_A: begin
        if (sts_i.r_in)      state_d = S_DN_B;
        else if (sts_i.l_in) state_d = S_DN_D;
        else                 state_d = S_FIN;
      end
      S_DN_B:  state_d = S_DN_C;
      S_DN_C:  state_d = S_DN_D;
      S_DN_D:  state_d = S_DN_E;
      S_DN_E:  state_d = S_DN_G;
      S_DN_G:  state_d = S_DN_F;
      S_DN_F:  state_d = sts_i.bc ? S_DN_A : S_FIN;
      S_FIN:   state_d = (sts_i.op == OP_BUILD) ? S_BLD_N : S_DONE;
      S_BLD_N: state_d = sts_i.bi_zero ? S_DONE : S_BLD_A;
      S_BLD_A: state_d = S_BLD_B;
      S_BLD_B: state_d = S_DN_A;
      S_CLR: begin
        if (sts_i.swp_last) begin
          state_d = init_q ? S_IDLE : S_DONE;
          init_d  = 1'b0;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State registers; reset starts with a sweep of the presence memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  // Command decode.
  always_comb begin
    unique case (state_q)
      S_IDLE:   cmd_o = CMD_IDLE;
      S_DISP:   cmd_o = CMD_DISP;
      S_EXT_A:  cmd_o = CMD_EXT_A;
      S_EXT_B:  cmd_o = CMD_EXT_B;
      S_TAKE_A: cmd_o = CMD_TAKE_A;
      S_TAKE_B: cmd_o = CMD_TAKE_B;
      S_TAKE_C: cmd_o = CMD_TAKE_C;
      S_UP_A:   cmd_o = CMD_UP_A;
      S_UP_B:   cmd_o = CMD_UP_B;
      S_UP_C:   cmd_o = CMD_UP_C;
      S_DN_A:   cmd_o = CMD_DN_A;
      S_DN_B:   cmd_o = CMD_DN_B;
      S_DN_C:   cmd_o = CMD_CMP;
      S_DN_D:   cmd_o = CMD_DN_D;
      S_DN_E:   cmd_o = CMD_DN_E;
      S_DN_G:   cmd_o = CMD_CMP;
      S_DN_F:   cmd_o = CMD_DN_F;
      S_FIN:    cmd_o = CMD_FIN;
      S_BLD_N:  cmd_o = CMD_BLD_N;
      S_BLD_A:  cmd_o = CMD_BLD_A;
      S_BLD_B:  cmd_o = CMD_BLD_B;
      S_CLR:    cmd_o = CMD_CLR;
      S_DONE:   cmd_o = CMD_DONE;
      default:  cmd_o = CMD_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

/* rtl/core/imh_dp.sv */
// Datapath of the indexed min-heap: the four memories, the count, the hole
// pointer used for sifting and the result registers. Depends on imh_pkg, imh_ram.
module imh_dp #(
  parameter int CAPACITY = imh_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imh_pkg::imh_req_t req_i,
  input  imh_pkg::imh_cmd_e cmd_i,
  output imh_pkg::imh_sts_t sts_o,
  output imh_pkg::imh_rsp_t rsp_o
);
  import imh_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CH_W   = CNT_W + 1;

  // Registers.
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SLOT_W-1:0]   hole_q, hole_d, bi_q, bi_d, chslot_q, chslot_d, cslot_q, cslot_d;
  logic [ITEM_W-1:0]   mv_id_q, mv_id_d, cid_q, cid_d, tid_q, tid_d, id_q, id_d;
  logic [ITEM_W-1:0]   r_item_q, r_item_d, swp_q, swp_d;
  logic [KEY_BITS-1:0] mv_key_q, mv_key_d, ckey_q, ckey_d, kin_q, kin_d;
  logic [KEY_BITS-1:0] r_key_q, r_key_d;
  logic [2:0]          op_q, op_d;
  logic [1:0]          r_st_q, r_st_d;
  logic                bc_q, bc_d, first_q, first_d;

  // Memory ports.
  logic                key_we, heap_we, pos_we, pres_we;
  logic [KEY_BITS-1:0] key_wd, key_rd;
  logic [ITEM_W-1:0]   key_ra, heap_wd, heap_rd, pos_wa, pres_wa;
  logic [SLOT_W-1:0]   heap_wa, heap_ra, pos_wd, pos_rd;
  logic                pres_wd, pres_rd;

  // Derived values.
  logic [CH_W-1:0]     l_idx, r_idx;
  logic [SLOT_W-1:0]   parent;
  logic [KEY_BITS-1:0] ref_key, dec_key;
  logic                valid_id, here, better;

  assign l_idx    = (CH_W'(hole_q) << 1) + CH_W'(1);
  assign r_idx    = l_idx + CH_W'(1);
  assign parent   = (hole_q - SLOT_W'(1)) >> 1;
  assign ref_key  = bc_q ? ckey_q : mv_key_q;
  assign better   = key_rd < ref_key;
  assign dec_key  = (key_rd == '0) ? key_rd : key_rd - KEY_BITS'(1);
  assign valid_id = 32'(id_q) < 32'(CAPACITY);
  assign here     = valid_id && pres_rd;

  // Status toward the controller.
  always_comb begin
    sts_o.op        = op_q;
    sts_o.valid_id  = valid_id;
    sts_o.here      = here;
    sts_o.full      = 32'(cnt_q) >= 32'(CAPACITY);
    sts_o.empty     = (cnt_q == '0);
    sts_o.hole_zero = (hole_q == '0);
    sts_o.first     = first_q;
    sts_o.up_gt     = key_rd > mv_key_q;
    sts_o.r_in      = r_idx < CH_W'(cnt_q);
    sts_o.l_in      = l_idx < CH_W'(cnt_q);
    sts_o.bc        = bc_q;
    sts_o.bi_zero   = (bi_q == '0);
    sts_o.take_need = CNT_W'(hole_q) < cnt_q;
    sts_o.swp_last  = (swp_q == '1);
  end

  // Read addresses: key reads follow the request while idle and otherwise the heap
  // read data; presence and position reads always follow the request.
  assign key_ra = (cmd_i == CMD_IDLE) ? req_i.item_id : heap_rd;

  always_comb begin
    case (cmd_i)
      CMD_TAKE_A: heap_ra = SLOT_W'(cnt_q);
      CMD_UP_A:   heap_ra = parent;
      CMD_DN_A:   heap_ra = r_idx[SLOT_W-1:0];
      CMD_DN_D:   heap_ra = l_idx[SLOT_W-1:0];
      CMD_BLD_N:  heap_ra = bi_q - SLOT_W'(1);
      default:    heap_ra = '0;
    endcase
  end

  // Command decode: next register values and memory writes.
  always_comb begin
    cnt_d = cnt_q;       hole_d = hole_q;     bi_d = bi_q;
    chslot_d = chslot_q; cslot_d = cslot_q;   mv_id_d = mv_id_q;
    cid_d = cid_q;       tid_d = tid_q;       id_d = id_q;
    r_item_d = r_item_q; swp_d = swp_q;       mv_key_d = mv_key_q;
    ckey_d = ckey_q;     kin_d = kin_q;       r_key_d = r_key_q;
    op_d = op_q;         r_st_d = r_st_q;     bc_d = bc_q;
    first_d = first_q;
    key_we = 1'b0;  key_wd = kin_q;
    heap_we = 1'b0; heap_wa = hole_q; heap_wd = mv_id_q;
    pos_we = 1'b0;  pos_wa = mv_id_q; pos_wd = hole_q;
    pres_we = 1'b0; pres_wa = id_q;   pres_wd = 1'b0;
    case (cmd_i)
      CMD_IDLE: begin
        op_d  = req_i.op;
        id_d  = req_i.item_id;
        kin_d = KEY_BITS'(req_i.item_key);
      end
      CMD_DISP: begin
        r_item_d = '0;
        r_key_d  = '0;
        r_st_d   = ST_OK;
        case (op_q)
          OP_CLEAR: begin
            cnt_d = '0;
            swp_d = '0;
          end
          OP_LOAD: begin
            r_item_d = id_q;
            if (!valid_id) begin
              r_st_d = ST_NOTP;
            end else if (here) begin
              key_we   = 1'b1;
              r_key_d  = kin_q;
              mv_id_d  = id_q;
              mv_key_d = kin_q;
              hole_d   = pos_rd;
              first_d  = 1'b1;
            end else if (sts_o.full) begin
              r_st_d = ST_FULL;
            end else begin
              key_we  = 1'b1;
              heap_we = 1'b1;
              heap_wa = SLOT_W'(cnt_q);
              heap_wd = id_q;
              pos_we  = 1'b1;
              pos_wa  = id_q;
              pos_wd  = SLOT_W'(cnt_q);
              pres_we = 1'b1;
              pres_wd = 1'b1;
              cnt_d   = cnt_q + CNT_W'(1);
              r_key_d = kin_q;
            end
          end
          OP_BUILD: bi_d = SLOT_W'(cnt_q >> 1);
          OP_EXTRACT: begin
            if (cnt_q == '0) r_st_d = ST_EMPTY;
          end
          OP_REMOVE: begin
            r_item_d = id_q;
            if (!here) begin
              r_st_d = ST_NOTP;
            end else begin
              r_key_d = key_rd;
              hole_d  = pos_rd;
              cnt_d   = cnt_q - CNT_W'(1);
              pres_we = 1'b1;
            end
          end
          OP_DEC: begin
            r_item_d = id_q;
            if (!here) begin
              r_st_d = ST_NOTP;
            end else begin
              key_we   = 1'b1;
              key_wd   = dec_key;
              r_key_d  = dec_key;
              mv_id_d  = id_q;
              mv_key_d = dec_key;
              hole_d   = pos_rd;
              first_d  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      CMD_EXT_A: r_item_d = heap_rd;
      CMD_EXT_B: begin
        r_key_d = key_rd;
        pres_we = 1'b1;
        pres_wa = r_item_q;
        cnt_d   = cnt_q - CNT_W'(1);
        hole_d  = '0;
      end
      CMD_TAKE_B: mv_id_d = heap_rd;
      CMD_TAKE_C: begin
        mv_key_d = key_rd;
        first_d  = 1'b1;
      end
      CMD_UP_B: cid_d = heap_rd;
      // Parent larger: it moves down into the hole.
      CMD_UP_C: begin
        if (key_rd > mv_key_q) begin
          heap_we = 1'b1;
          heap_wd = cid_q;
          pos_we  = 1'b1;
          pos_wa  = cid_q;
          hole_d  = parent;
          first_d = 1'b0;
        end
      end
      CMD_DN_A: begin
        bc_d     = 1'b0;
        chslot_d = r_idx[SLOT_W-1:0];
      end
      CMD_DN_B: tid_d = heap_rd;
      CMD_DN_D: chslot_d = l_idx[SLOT_W-1:0];
      CMD_DN_E: tid_d = heap_rd;
      // Keep the child with the strictly smaller key.
      CMD_CMP: begin
        if (better) begin
          cid_d   = tid_q;
          ckey_d  = key_rd;
          cslot_d = chslot_q;
          bc_d    = 1'b1;
        end
      end
      // Best child moves up into the hole.
      CMD_DN_F: begin
        if (bc_q) begin
          heap_we = 1'b1;
          heap_wd = cid_q;
          pos_we  = 1'b1;
          pos_wa  = cid_q;
          hole_d  = cslot_q;
        end
      end
      CMD_FIN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      CMD_BLD_N: begin
        if (bi_q != '0) begin
          bi_d   = bi_q - SLOT_W'(1);
          hole_d = bi_q - SLOT_W'(1);
        end
      end
      CMD_BLD_A: mv_id_d = heap_rd;
      CMD_BLD_B: mv_key_d = key_rd;
      CMD_CLR: begin
        pres_we = 1'b1;
        pres_wa = swp_q;
        swp_d   = swp_q + ITEM_W'(1);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      swp_q   <= '0;
      bc_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      swp_q   <= swp_d;
      bc_q    <= bc_d;
      first_q <= first_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hole_q   <= hole_d;   bi_q    <= bi_d;    chslot_q <= chslot_d;
    cslot_q  <= cslot_d;  mv_id_q <= mv_id_d; cid_q    <= cid_d;
    tid_q    <= tid_d;    id_q    <= id_d;    r_item_q <= r_item_d;
    mv_key_q <= mv_key_d; ckey_q  <= ckey_d;  kin_q    <= kin_d;
    r_key_q  <= r_key_d;  op_q    <= op_d;    r_st_q   <= r_st_d;
  end

  // Memories.
  imh_ram #(.WIDTH(KEY_BITS), .DEPTH(ID_DEPTH)) u_key_mem (
    .clk_i, .we_i(key_we), .waddr_i(id_q), .wdata_i(key_wd),
    .raddr_i(key_ra), .rdata_o(key_rd)
  );
  imh_ram #(.WIDTH(ITEM_W), .DEPTH(CAPACITY)) u_heap_mem (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .raddr_i(heap_ra), .rdata_o(heap_rd)
  );
  imh_ram #(.WIDTH(SLOT_W), .DEPTH(ID_DEPTH)) u_pos_mem (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(req_i.item_id), .rdata_o(pos_rd)
  );
  imh_ram #(.WIDTH(1), .DEPTH(ID_DEPTH)) u_pres_mem (
    .clk_i, .we_i(pres_we), .waddr_i(pres_wa), .wdata_i(pres_wd),
    .raddr_i(req_i.item_id), .rdata_o(pres_rd)
  );

  // Result.
  assign rsp_o.out_item   = r_item_q;
  assign rsp_o.out_key    = IKEY_W'(r_key_q);
  assign rsp_o.status     = r_st_q;
  assign rsp_o.live_count = LCNT_W'(cnt_q);

endmodule

/* rtl/core/indexed_min_heap_top.sv */
// Top level of the indexed binary min-heap with decrease-key.
// Depends on imh_pkg, imh_ctrl and imh_dp (which holds the imh_ram instances).
//
//   Channel   Ports                 Handshake
//   request   req_i, start          transfer when start && !busy
//   result    rsp_o, done_o         one-cycle strobe, no back-pressure
//
// An operation passes through dispatch, the result strobe and an idle state between
// one transfer and the next. A sift up reads the parent and its key at each level;
// a sift down reads the heap and then the key of each child, right then left, and
// moves the better child up; checks stop the sift and a final write places the item.
// Extract and remove fetch the last item into the hole. Build sifts down each inner
// node in turn. Clear sweeps all entries of the presence memory; after reset the same
// sweep runs with busy high. The result is shown for one cycle and cannot be stalled.
module indexed_min_heap_top #(
  parameter int CAPACITY = imh_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = imh_pkg::DEF_KEY_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  imh_pkg::imh_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output imh_pkg::imh_rsp_t rsp_o
);
  import imh_pkg::*;

  imh_cmd_e cmd;
  imh_sts_t sts;

  imh_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .sts_i(sts), .cmd_o(cmd), .busy, .done_o
  );

  imh_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

  // An accepted request keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  // After a result the block is ready again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("block stayed busy after result");

  // Live count never exceeds capacity.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(rsp_o.live_count) <= 32'(CAPACITY)))
    else $error("live count beyond capacity");

  // An empty status always reports an empty heap.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |-> (rsp_o.live_count == '0))
    else $error("empty status with live items");

endmodule
